>>> hw/rtl/cal_pkg.sv
// Shared types and constants for the compacting array list unit.
// No dependencies.
package cal_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 9;

   typedef logic [1:0]                mode_type;
   typedef logic signed [DATA_W-1:0]  value_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [FILL_W-1:0]         fill_type;

   localparam mode_type MODE_APPEND       = 2'd0;
   localparam mode_type MODE_REMOVE_VALUE = 2'd1;
   localparam mode_type MODE_REMOVE_POS   = 2'd2;
   localparam mode_type MODE_READ         = 2'd3;

endpackage

>>> hw/rtl/cal_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module cal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/compacting_array_list_unit.sv
// Compacting array list: a packed list of signed 32-bit entries in one RAM.
// Depends on cal_pkg and cal_ram.
//
// Usage:
//   A request (req_mode, req_value, req_position) is taken on req_valid and
//   req_ready. Modes: append, remove first equal value, remove at position,
//   read at position. Each request gives exactly one response on the rsp_
//   channel: rsp_ok, rsp_count (entries held afterwards) and rsp_read_value
//   (entry read in read mode on success, otherwise zero).
//   One request is worked at a time; req_ready is high while the sequencer
//   is idle. Steps from accept to response valid:
//     append or failed index check: straight to the done state
//     read: a wait for the RAM read data, then the done state
//     removals: a read and a compare per entry searched, then a read and a
//     write per entry moved down, then the done state; a search that finds
//     nothing goes to the done state at the end of the list.
//   The single RAM read port sets the pace of the search and the shift.
//   The response sits in an output register; the next request is accepted
//   while it waits, and the sequencer holds its finished result if the
//   receiver still stalls the previous one.
//   Reset empties the list (count zero); RAM contents are not cleared.
module compacting_array_list_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cal_pkg::mode_type  req_mode,
   input  cal_pkg::value_type req_value,
   input  cal_pkg::pos_type   req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output cal_pkg::count_type rsp_count,
   output cal_pkg::value_type rsp_read_value
);
   import cal_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SRCH_RD  = 3'd1;
   localparam logic [2:0] S_SRCH_CMP = 3'd2;
   localparam logic [2:0] S_SHF_RD   = 3'd3;
   localparam logic [2:0] S_SHF_WR   = 3'd4;
   localparam logic [2:0] S_RD_WAIT  = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;
   fill_type   fill_ff, fill_in;
   idx_type    idx_ff, idx_in;
   value_type  value_ff, value_in;
   logic       ok_ff, ok_in;
   value_type  rdv_ff, rdv_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff;
   count_type  rsp_count_ff;
   value_type  rsp_rdv_ff;
   logic       load;

   fill_type   next_idx;
   logic       ram_we;
   idx_type    ram_waddr;
   value_type  ram_wdata;
   idx_type    ram_raddr;
   value_type  ram_rdata;

   cal_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY),
      .AW   (IDX_W)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign next_idx  = {1'b0, idx_ff} + FILL_W'(1);

   // Shift writes entry idx then reads idx+2; a read whose data is used never
   // hits the entry written in the same cycle, so no forwarding is needed.
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      ok_in     = ok_ff;
      rdv_in    = rdv_ff;
      load      = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               ok_in    = 1'b0;
               rdv_in   = '0;
               state_in = S_DONE;
               unique case (req_mode)
                  MODE_APPEND: begin
                     if (fill_ff < FILL_W'(CAPACITY)) begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_ff[IDX_W-1:0];
                        ram_wdata = req_value;
                        fill_in   = fill_ff + FILL_W'(1);
                        ok_in     = 1'b1;
                     end
                  end
                  MODE_REMOVE_VALUE: begin
                     idx_in = '0;
                     if (fill_ff != '0) begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  MODE_REMOVE_POS: begin
                     if (req_position < POS_W'(fill_ff)) begin
                        idx_in   = req_position[IDX_W-1:0];
                        state_in = S_SHF_RD;
                     end
                  end
                  MODE_READ: begin
                     if (req_position < POS_W'(fill_ff)) begin
                        ram_raddr = req_position[IDX_W-1:0];
                        state_in  = S_RD_WAIT;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SRCH_RD: begin
            ram_raddr = idx_ff;
            state_in  = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (ram_rdata == value_ff) begin
               state_in = S_SHF_RD;
            end else if (next_idx < fill_ff) begin
               idx_in   = next_idx[IDX_W-1:0];
               state_in = S_SRCH_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SHF_RD: begin
            if (next_idx < fill_ff) begin
               ram_raddr = next_idx[IDX_W-1:0];
               state_in  = S_SHF_WR;
            end else begin
               fill_in  = fill_ff - FILL_W'(1);
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_SHF_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            idx_in    = next_idx[IDX_W-1:0];
            state_in  = S_SHF_RD;
         end
         S_RD_WAIT: begin
            rdv_in   = ram_rdata;
            ok_in    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      value_ff <= value_in;
      ok_ff    <= ok_in;
      rdv_ff   <= rdv_in;
      if (load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_count_ff <= COUNT_W'(fill_ff);
         rsp_rdv_ff   <= rdv_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = rsp_rdv_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count above capacity");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, ram_waddr} <= fill_ff))
      else $error("RAM write beyond list end");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_SHF_RD) |=> $stable(fill_ff))
      else $error("fill count changed outside append or shift end");

   a_rdv_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_value != '0) |-> rsp_ok)
      else $error("read value on failed response");

endmodule

>>> tb/compacting_array_list_unit_test.sv
// Testbench for compacting_array_list_unit: a directed table, then random list traffic
// under several idle and stall patterns, each response checked against a list mirror or a typed table row.
// Depends on cal_pkg and the RTL of compacting_array_list_unit.
`timescale 1ns / 100ps

module compacting_array_list_unit_test;
   import cal_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam int NUM_DIRECTED = 28;
   localparam int PHASE_ITEMS  = 470;

   typedef struct packed {
      logic      ok;
      count_type count;
      value_type read_value;
   } list_response_type;

   typedef struct packed {
      mode_type          mode;
      value_type         value;
      pos_type           pos;
      bit                typed;
      list_response_type want;
   } directed_row_type;

   localparam list_response_type UNTYPED = '{1'b0, 9'd0, 32'sd0};

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   mode_type  req_mode;
   value_type req_value;
   pos_type   req_position;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_ok;
   count_type rsp_count;
   value_type rsp_read_value;

   value_type         mirror_entries [CAPACITY];
   int                mirror_fill;
   list_response_type pending [$];
   int                mismatch_count;
   int                quiet_cycles;
   int                send_idle_pct;
   int                stall_pct;
   bit                hold_request;
   int                sent_by_mode [4];
   int                ok_by_mode [4];
   int                responses_seen;

   value_type corner_values [4] = '{32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sd0};

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{MODE_READ,         32'sd0,         8'd0,   1'b1, '{1'b0, 9'd0,  32'sd0}},
      '{MODE_REMOVE_POS,   32'sd0,         8'd0,   1'b1, '{1'b0, 9'd0,  32'sd0}},
      '{MODE_REMOVE_VALUE, 32'sd0,         8'd0,   1'b1, '{1'b0, 9'd0,  32'sd0}},
      '{MODE_APPEND,       32'sh80000000,  8'd0,   1'b1, '{1'b1, 9'd1,  32'sd0}},
      '{MODE_APPEND,       32'sh7FFFFFFF,  8'd0,   1'b1, '{1'b1, 9'd2,  32'sd0}},
      '{MODE_APPEND,       32'shFFFFFFFF,  8'd0,   1'b1, '{1'b1, 9'd3,  32'sd0}},
      '{MODE_APPEND,       32'sd0,         8'd0,   1'b1, '{1'b1, 9'd4,  32'sd0}},
      '{MODE_READ,         32'sd0,         8'd0,   1'b1, '{1'b1, 9'd4,  32'sh80000000}},
      '{MODE_APPEND,       32'sh7FFFFFFF,  8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sh55555555,  8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'shAAAAAAAA,  8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd1,         8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sh80000001,  8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sh12345678,  8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'shFEDCBA98,  8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd2,         8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd3,         8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd4,         8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd5,         8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd6,         8'd0,   1'b0, UNTYPED},
      '{MODE_APPEND,       32'sd7,         8'd0,   1'b1, '{1'b0, 9'd16, 32'sd0}},
      '{MODE_READ,         32'sd0,         8'd16,  1'b1, '{1'b0, 9'd16, 32'sd0}},
      '{MODE_READ,         32'shFFFFFFFF,  8'd255, 1'b1, '{1'b0, 9'd16, 32'sd0}},
      '{MODE_REMOVE_VALUE, 32'sh7FFFFFFE,  8'd0,   1'b1, '{1'b0, 9'd16, 32'sd0}},
      '{MODE_REMOVE_VALUE, 32'sh7FFFFFFF,  8'd0,   1'b0, UNTYPED},
      '{MODE_REMOVE_POS,   32'sd0,         8'd0,   1'b0, UNTYPED},
      '{MODE_REMOVE_POS,   32'sd0,         8'd13,  1'b0, UNTYPED},
      '{MODE_READ,         32'sd0,         8'd12,  1'b0, UNTYPED}
   };

   compacting_array_list_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count),
      .rsp_read_value (rsp_read_value)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void drop_entry(input int idx);
      for (int i = idx; i + 1 < mirror_fill; i++) begin
         mirror_entries[i] = mirror_entries[i + 1];
      end
      mirror_fill--;
   endfunction

   function automatic list_response_type apply_list_op(input mode_type m, input value_type v,
                                                       input pos_type p);
      list_response_type r;
      int hit;
      r = UNTYPED;
      hit = -1;
      case (m)
         MODE_APPEND: begin
            if (mirror_fill < CAPACITY) begin
               mirror_entries[mirror_fill] = v;
               mirror_fill++;
               r.ok = 1'b1;
            end
         end
         MODE_REMOVE_VALUE: begin
            for (int i = 0; i < mirror_fill; i++) begin
               if (hit < 0 && mirror_entries[i] == v) hit = i;
            end
            if (hit >= 0) begin
               drop_entry(hit);
               r.ok = 1'b1;
            end
         end
         MODE_REMOVE_POS: begin
            if (int'(p) < mirror_fill) begin
               drop_entry(int'(p));
               r.ok = 1'b1;
            end
         end
         default: begin
            if (int'(p) < mirror_fill) begin
               r.read_value = mirror_entries[p];
               r.ok = 1'b1;
            end
         end
      endcase
      r.count = count_type'(mirror_fill);
      return r;
   endfunction

   // entered just after a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input mode_type m, input value_type v, input pos_type p,
                               input bit typed, input list_response_type want);
      list_response_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_mode     = m;
      req_value    = v;
      req_position = p;
      do @(posedge clock); while (!req_ready);
      predicted = apply_list_op(m, v, p);
      pending.push_back(typed ? want : predicted);
      sent_by_mode[m]++;
      if (predicted.ok) ok_by_mode[m]++;
      @(negedge clock);
   endtask

   task automatic random_requests(input int n);
      mode_type m;
      value_type v;
      pos_type p;
      int r;
      bit grow;
      grow = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (k % 64 == 0) grow = $urandom_range(1);
         r = $urandom_range(99);
         if (r < (grow ? 55 : 20)) m = MODE_APPEND;
         else if (r < (grow ? 70 : 50)) m = MODE_REMOVE_VALUE;
         else if (r < (grow ? 82 : 75)) m = MODE_REMOVE_POS;
         else m = MODE_READ;
         r = $urandom_range(99);
         if (mirror_fill > 0 && r < 45)
            v = mirror_entries[$urandom_range(mirror_fill - 1)];
         else if (mirror_fill > 0 && r < 55)
            v = mirror_entries[$urandom_range(mirror_fill - 1)]
                ^ value_type'(32'h1 << $urandom_range(31));
         else if (r < 65)
            v = corner_values[$urandom_range(3)];
         else
            v = value_type'($urandom);
         if ($urandom_range(99) < 80) p = pos_type'($urandom_range(mirror_fill));
         else p = pos_type'($urandom_range(255));
         send_request(m, v, p, 1'b0, UNTYPED);
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      bit hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      list_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
               mismatch_count++;
            end
            if (rsp_count !== want.count) begin
               $error("rsp_count: expected %0d, got %0d", want.count, rsp_count);
               mismatch_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("rsp_read_value: expected %h, got %h", want.read_value, rsp_read_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("compacting_array_list_unit_test: done, errors");
      $finish;
   end

   initial begin : main_flow
      int send_pcts [4];
      int stall_pcts [4];
      send_pcts      = '{0, 83, 0, 35};
      stall_pcts     = '{0, 0, 83, 35};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_APPEND;
      req_value      = '0;
      req_position   = '0;
      mirror_fill    = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      hold_request   = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sent_by_mode[i] = 0;
         ok_by_mode[i]   = 0;
      end
      foreach (mirror_entries[i]) mirror_entries[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].mode, directed_rows[i].value, directed_rows[i].pos,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_pcts[ph];
         stall_pct     = stall_pcts[ph];
         if (ph == 0) begin
            // long receiver hold-off while requests keep coming, to back up the block
            req_valid = 1'b0;
            @(posedge clock);
            hold_request = 1'b1;
            @(negedge clock);
         end
         random_requests(PHASE_ITEMS);
      end
      req_valid = 1'b0;

      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d responses; append %0d/%0d ok, remove-value %0d/%0d, remove-pos %0d/%0d",
               responses_seen, ok_by_mode[MODE_APPEND], sent_by_mode[MODE_APPEND],
               ok_by_mode[MODE_REMOVE_VALUE], sent_by_mode[MODE_REMOVE_VALUE],
               ok_by_mode[MODE_REMOVE_POS], sent_by_mode[MODE_REMOVE_POS]);
      $display("read %0d/%0d ok, under idle, stall and long hold-off patterns",
               ok_by_mode[MODE_READ], sent_by_mode[MODE_READ]);
      if (mismatch_count == 0) begin
         $display("compacting_array_list_unit_test: done, clean");
      end else begin
         $display("compacting_array_list_unit_test: done, errors");
      end
      $finish;
   end

endmodule
